// File: hdl/vdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdr_pkg: shared types and constants of the virtqueue descriptor ring
// Word formats of the request and response channels, the descriptor table
// entry layout, command and result codes.
// ----------------------------------------------------------------------------
package vdr_pkg;

   localparam int RING_SIZE = 16;
   localparam int IDX_W     = $clog2(RING_SIZE);
   // Longest chain a reclaim walks before it stops.
   localparam int WALK_CAP  = (RING_SIZE < 16) ? RING_SIZE : 16;
   localparam int WALK_W    = (WALK_CAP > 1) ? $clog2(WALK_CAP) : 1;

   localparam logic       CMD_SUBMIT  = 1'b0;
   localparam logic       CMD_RECLAIM = 1'b1;

   localparam logic [1:0] KIND_SUBMITTED = 2'd0;
   localparam logic [1:0] KIND_BUSY      = 2'd1;
   localparam logic [1:0] KIND_FREED     = 2'd2;

   localparam logic [15:0] FLAG_NEXT  = 16'h0001;
   localparam logic [15:0] FLAG_WRITE = 16'h0002;

   typedef struct packed {
      logic        command;
      logic [63:0] buf_addr;
      logic [31:0] buf_len;
      logic [15:0] extra_flags;
      logic        chain_end;
      logic [3:0]  used_id;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic [63:0] out_addr;
      logic [31:0] out_len;
      logic [15:0] out_flags;
      logic [3:0]  out_next;
      logic        avail_posted;
      logic [3:0]  avail_position;
      logic [3:0]  avail_head;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [63:0]      addr;
      logic [31:0]      len;
      logic [15:0]      flags;
      logic [IDX_W-1:0] next;
   } entry_type;

endpackage

// File: hdl/virtqueue_descriptor_ring_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtqueue_descriptor_ring_unit: driver-side split virtqueue descriptor ring
// Builds descriptor chains in a circular table, posts chain heads to the
// avail ring and reclaims used chains descriptor by descriptor.
// ----------------------------------------------------------------------------
// A submit word writes one descriptor at the next free slot and returns one
// response word: submitted (with the avail ring post on the final descriptor
// of a chain) or slot busy. A reclaim word walks the chain starting at
// used_id, clears each descriptor and returns one freed word per descriptor,
// at most 16, with last set on the final one. The descriptor table sits in a
// single synchronous memory with a registered read; per-entry valid flops make
// the table read as all zero right after reset, so no clearing pass is
// needed and the block takes words from the first cycle. A submit makes a
// table read, then a check and write; a reclaim makes one table read per
// chain link. Both stall while the response register is still full.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_ring_unit
   import vdr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // Control state
   state_type          state_ff,      state_in;
   logic [IDX_W-1:0]   free_ff,       free_in;
   logic               chain_open_ff, chain_open_in;
   logic [IDX_W-1:0]   chain_head_ff, chain_head_in;
   logic [IDX_W-1:0]   avail_ff,      avail_in;
   logic [WALK_W-1:0]  walk_cnt_ff,   walk_cnt_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [RING_SIZE-1:0] vld_ff;

   // Payload state
   req_word_type       item_ff,       item_in;
   logic [IDX_W-1:0]   cur_idx_ff,    cur_idx_in;
   rsp_word_type       rsp_data_ff,   rsp_data_in;
   entry_type          rd_data_ff;
   logic               rd_vld_ff,     rd_vld_in;

   // Descriptor table
   entry_type          mem [RING_SIZE];

   logic               out_free;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic               clr_en;
   entry_type          wr_entry;
   entry_type          rd_entry;
   logic               more;
   logic               walk_stop;
   logic               is_end;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A cleared (invalid) entry reads as all zero.
   assign rd_entry  = rd_vld_ff ? rd_data_ff : '0;
   assign more      = (rd_entry.flags & FLAG_NEXT) != 16'h0000;
   assign walk_stop = !more || (walk_cnt_ff == WALK_W'(WALK_CAP - 1));
   assign is_end    = item_ff.chain_end;

   always_comb begin
      wr_entry.addr  = item_ff.buf_addr;
      wr_entry.len   = item_ff.buf_len;
      wr_entry.flags = item_ff.extra_flags | (is_end ? FLAG_WRITE : FLAG_NEXT);
      wr_entry.next  = is_end ? '0 : IDX_W'(cur_idx_ff + 1'b1);
   end

   always_comb begin
      state_in      = state_ff;
      free_in       = free_ff;
      chain_open_in = chain_open_ff;
      chain_head_in = chain_head_ff;
      avail_in      = avail_ff;
      walk_cnt_in   = walk_cnt_ff;
      item_in       = item_ff;
      cur_idx_in    = cur_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = cur_idx_ff;
      wr_en         = 1'b0;
      clr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // Issue the table read for the slot this word touches.
            rd_addr = (req_data.command == CMD_RECLAIM) ? IDX_W'(req_data.used_id) : free_ff;
            if (req_valid) begin
               item_in     = req_data;
               cur_idx_in  = rd_addr;
               walk_cnt_in = '0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.slot = 4'(cur_idx_ff);
               if (item_ff.command == CMD_SUBMIT) begin
                  rsp_data_in.last = 1'b1;
                  state_in         = ST_IDLE;
                  if (!chain_open_ff) begin
                     chain_head_in = cur_idx_ff;
                  end
                  if (rd_vld_ff) begin
                     // Slot still in use: drop the open chain, keep what was written.
                     rsp_data_in.kind = KIND_BUSY;
                     chain_open_in    = 1'b0;
                  end else begin
                     rsp_data_in.kind = KIND_SUBMITTED;
                     wr_en            = 1'b1;
                     free_in          = IDX_W'(cur_idx_ff + 1'b1);
                     if (is_end) begin
                        rsp_data_in.avail_posted   = 1'b1;
                        rsp_data_in.avail_position = 4'(avail_ff);
                        rsp_data_in.avail_head     = chain_open_ff ? 4'(chain_head_ff)
                                                                   : 4'(cur_idx_ff);
                        avail_in      = IDX_W'(avail_ff + 1'b1);
                        chain_open_in = 1'b0;
                     end else begin
                        chain_open_in = 1'b1;
                     end
                  end
               end else begin
                  // Emit and free one descriptor, then follow its link.
                  clr_en               = 1'b1;
                  rsp_data_in.kind     = KIND_FREED;
                  rsp_data_in.out_addr = rd_entry.addr;
                  rsp_data_in.out_len  = rd_entry.len;
                  rsp_data_in.out_flags = rd_entry.flags;
                  rsp_data_in.out_next = 4'(rd_entry.next);
                  if (walk_stop) begin
                     rsp_data_in.last = 1'b1;
                     state_in         = ST_IDLE;
                  end else begin
                     rd_addr     = rd_entry.next;
                     cur_idx_in  = rd_entry.next;
                     walk_cnt_in = WALK_W'(walk_cnt_ff + 1'b1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Forward a clear in flight to a read of the same slot.
   assign rd_vld_in = vld_ff[rd_addr] && !(clr_en && (cur_idx_ff == rd_addr));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_ff       <= '0;
         chain_open_ff <= 1'b0;
         chain_head_ff <= '0;
         avail_ff      <= '0;
         walk_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         vld_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         free_ff       <= free_in;
         chain_open_ff <= chain_open_in;
         chain_head_ff <= chain_head_in;
         avail_ff      <= avail_in;
         walk_cnt_ff   <= walk_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[cur_idx_ff] <= 1'b1;
         end else if (clr_en) begin
            vld_ff[cur_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      cur_idx_ff  <= cur_idx_in;
      rsp_data_ff <= rsp_data_in;
      rd_vld_ff   <= rd_vld_in;
   end

   // Descriptor table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cur_idx_ff] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // A taken word always starts the table access cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EXEC)
      else $error("accepted word did not enter execution");

   // Never overwrite a descriptor that is still in use.
   a_write_free_slot: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !vld_ff[cur_idx_ff])
      else $error("descriptor written over a busy slot");

   // A busy slot closes the open chain.
   a_busy_closes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && out_free && item_ff.command == CMD_SUBMIT && rd_vld_ff
      |=> !chain_open_ff && rsp_valid_ff && rsp_data_ff.kind == KIND_BUSY)
      else $error("busy slot did not abandon the chain");

   // The freed word at the walk cap is final.
   a_walk_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && out_free && item_ff.command == CMD_RECLAIM
      && walk_cnt_ff == WALK_W'(WALK_CAP - 1) |=> rsp_data_ff.last && state_ff == ST_IDLE)
      else $error("reclaim walk ran past its cap");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the virtqueue descriptor ring unit
// Runs a directed probe table and then random chain traffic. Both ends of the
// valid/ready handshake idle and stall at random. A descriptor ring predictor
// inside the bench checks every response word field by field.
// ----------------------------------------------------------------------------
module tb
   import vdr_pkg::*;
();

   localparam int STIM_WORDS   = 180;     // stop the random part around here
   localparam int CYCLE_LIMIT  = 600000;  // run aborts past this many cycles
   localparam int DRAIN_CYCLES = 40;      // quiet cycles after the last response
   localparam int REPORT_MAX   = 10;

   // Directed probe: one request word, plus a hand-written response where it
   // is obvious; otherwise the predictor supplies the expectation.
   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type rsp;
   } probe_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   // Predictor state: a private copy of the descriptor table and ring pointers
   entry_type        pred_table [RING_SIZE];
   logic [IDX_W-1:0] pred_next_free;
   logic             pred_chain_open;
   logic [IDX_W-1:0] pred_chain_head;
   logic [15:0]      pred_avail_count;

   rsp_word_type     ring_expected [$];  // response words still owed by the dut
   logic [IDX_W-1:0] posted_heads [$];   // chain heads posted to the avail ring
   probe_row_type    probe_rows [$];

   int  words_sent;
   int  responses_seen;
   int  mismatches;
   int  submits_seen;
   int  reclaims_seen;
   int  chains_posted;
   int  busy_seen;
   int  cycles;
   int  sink_hold;
   bit  calm;                             // when set, neither side idles

   virtqueue_descriptor_ring_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------------

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm) return 0;
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic req_word_type mk_submit(logic [63:0] addr, logic [31:0] len,
                                              logic [15:0] flags, logic end_bit);
      req_word_type w;
      w             = '0;
      w.command     = CMD_SUBMIT;
      w.buf_addr    = addr;
      w.buf_len     = len;
      w.extra_flags = flags;
      w.chain_end   = end_bit;
      return w;
   endfunction

   function automatic req_word_type mk_reclaim(logic [3:0] id);
      req_word_type w;
      w         = '0;
      w.command = CMD_RECLAIM;
      w.used_id = id;
      return w;
   endfunction

   // Single-word response with zero descriptor fields and last set.
   function automatic rsp_word_type mk_rsp(logic [1:0] kind, logic [3:0] slot,
                                           logic posted, logic [3:0] pos,
                                           logic [3:0] head);
      rsp_word_type r;
      r                = '0;
      r.kind           = kind;
      r.slot           = slot;
      r.avail_posted   = posted;
      r.avail_position = pos;
      r.avail_head     = head;
      r.last           = 1'b1;
      return r;
   endfunction

   // Random submit: fields the dut ignores on a submit get noise too.
   function automatic req_word_type rand_submit(bit end_bit);
      req_word_type w;
      logic [15:0]  flags;
      flags     = ($urandom_range(0, 9) < 7) ? 16'h0000 : 16'($urandom_range(0, 65535));
      w         = mk_submit({$urandom(), $urandom()}, $urandom(), flags, end_bit);
      w.used_id = 4'($urandom_range(0, 15));
      return w;
   endfunction

   function automatic req_word_type rand_reclaim(logic [3:0] id);
      req_word_type w;
      w             = mk_submit({$urandom(), $urandom()}, $urandom(),
                                16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      w.command     = CMD_RECLAIM;
      w.used_id     = id;
      return w;
   endfunction

   function automatic int live_slots();
      int n;
      n = 0;
      foreach (pred_table[k]) if (pred_table[k].flags != 16'h0000) n++;
      return n;
   endfunction

   function automatic string rsp_text(rsp_word_type r);
      return $sformatf({"kind %0d slot %0d addr %h len %h flags %h next %0d ",
                        "posted %0d pos %0d head %0d last %0d"},
                       r.kind, r.slot, r.out_addr, r.out_len, r.out_flags, r.out_next,
                       r.avail_posted, r.avail_position, r.avail_head, r.last);
   endfunction

   // ------------------------------------------------------------------------
   // Ring predictor: apply one request word to the private table and queue
   // the response words it causes.
   // ------------------------------------------------------------------------
   function automatic void ring_predict(req_word_type w);
      rsp_word_type     r;
      entry_type        e;
      logic [IDX_W-1:0] idx;
      int               walked;
      bit               more;
      r      = '0;
      r.last = 1'b1;
      if (w.command == CMD_SUBMIT) begin
         submits_seen++;
         idx    = pred_next_free;
         r.slot = idx;
         // Open a new chain at the slot about to be written.
         if (!pred_chain_open) begin
            pred_chain_head = idx;
            pred_chain_open = 1'b1;
         end
         if (pred_table[idx].flags != 16'h0000) begin
            // Slot still in use: write nothing, hold the pointer, drop the chain.
            busy_seen++;
            pred_chain_open = 1'b0;
            r.kind          = KIND_BUSY;
         end else begin
            e.addr  = w.buf_addr;
            e.len   = w.buf_len;
            e.flags = w.extra_flags | (w.chain_end ? FLAG_WRITE : FLAG_NEXT);
            e.next  = w.chain_end ? '0 : idx + 1'b1;
            pred_table[idx] = e;
            pred_next_free  = idx + 1'b1;
            r.kind          = KIND_SUBMITTED;
            if (w.chain_end) begin
               // Post the head to the avail ring and close the chain.
               chains_posted++;
               r.avail_posted   = 1'b1;
               r.avail_position = pred_avail_count[IDX_W-1:0];
               r.avail_head     = pred_chain_head;
               posted_heads.push_back(pred_chain_head);
               pred_avail_count = pred_avail_count + 16'd1;
               pred_chain_open  = 1'b0;
            end
         end
         ring_expected.push_back(r);
      end else begin
         reclaims_seen++;
         idx    = w.used_id;
         walked = 0;
         more   = 1'b1;
         // Walk the chain, clear each entry, stop at the cap or a missing next flag.
         while (more && walked < WALK_CAP) begin
            e               = pred_table[idx];
            pred_table[idx] = '0;
            walked++;
            more        = (e.flags & FLAG_NEXT) != 16'h0000;
            r           = '0;
            r.kind      = KIND_FREED;
            r.slot      = idx;
            r.out_addr  = e.addr;
            r.out_len   = e.len;
            r.out_flags = e.flags;
            r.out_next  = e.next;
            r.last      = !more || walked == WALK_CAP;
            ring_expected.push_back(r);
            idx = e.next;
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request side: offer one word and hold it until the dut takes it. Called
   // on a rising edge; returns on the edge that accepted the word.
   // ------------------------------------------------------------------------
   task automatic drive_word(req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      // Now and then flip between idling and a no-gap stretch.
      if ($urandom_range(0, 39) == 0) calm = !calm;
   endtask

   task automatic issue(req_word_type w);
      ring_predict(w);
      drive_word(w);
   endtask

   // ------------------------------------------------------------------------
   // Response side: ready drops for random stretches, stays high for others.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      int stall;
      if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
      end else if (rsp_ready) begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            sink_hold <= stall - 1;
         end else begin
            sink_hold <= $urandom_range(0, 15);
         end
      end else begin
         rsp_ready <= 1'b1;
         sink_hold <= $urandom_range(0, 15);
      end
   end

   // ------------------------------------------------------------------------
   // Checker: every accepted response word against the oldest expectation.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      string        bad;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (ring_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("tb: response word with nothing pending: %s", rsp_text(rsp_data));
         end else begin
            want = ring_expected.pop_front();
            bad  = "";
            if (rsp_data.kind           !== want.kind)           bad = {bad, " kind"};
            if (rsp_data.slot           !== want.slot)           bad = {bad, " slot"};
            if (rsp_data.out_addr       !== want.out_addr)       bad = {bad, " out_addr"};
            if (rsp_data.out_len        !== want.out_len)        bad = {bad, " out_len"};
            if (rsp_data.out_flags      !== want.out_flags)      bad = {bad, " out_flags"};
            if (rsp_data.out_next       !== want.out_next)       bad = {bad, " out_next"};
            if (rsp_data.avail_posted   !== want.avail_posted)   bad = {bad, " avail_posted"};
            if (rsp_data.avail_position !== want.avail_position) bad = {bad, " avail_position"};
            if (rsp_data.avail_head     !== want.avail_head)     bad = {bad, " avail_head"};
            if (rsp_data.last           !== want.last)           bad = {bad, " last"};
            if (bad != "") begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("tb: response %0d differs in%s", responses_seen, bad);
                  $display("tb:   expected %s", rsp_text(want));
                  $display("tb:   actual   %s", rsp_text(rsp_data));
               end
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: timed out after %0d cycles, %0d response words outstanding",
                  cycles, ring_expected.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      probe_row_type row;
      int            n0;
      int            len;
      int            pick;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      calm      = 1'b0;
      foreach (pred_table[k]) pred_table[k] = '0;
      pred_next_free   = '0;
      pred_chain_open  = 1'b0;
      pred_chain_head  = '0;
      pred_avail_count = '0;

      // Directed probes, starting from the cleared table.
      // Reclaim an empty entry at both ends of the index range.
      probe_rows.push_back('{mk_reclaim(4'd0), 1'b1, mk_rsp(KIND_FREED, 4'd0, 1'b0, 4'd0, 4'd0)});
      probe_rows.push_back('{mk_reclaim(4'd15), 1'b1,
                             mk_rsp(KIND_FREED, 4'd15, 1'b0, 4'd0, 4'd0)});
      // Two-descriptor chain at the field extremes; the final one carries all
      // caller flags, next bit included, so its link must still read zero.
      probe_rows.push_back('{mk_submit('1, '1, 16'h0000, 1'b0), 1'b1,
                             mk_rsp(KIND_SUBMITTED, 4'd0, 1'b0, 4'd0, 4'd0)});
      probe_rows.push_back('{mk_submit('0, '0, 16'hFFFF, 1'b1), 1'b1,
                             mk_rsp(KIND_SUBMITTED, 4'd1, 1'b1, 4'd0, 4'd0)});
      // Reclaim it: the stray next flag drags the walk back to the cleared head.
      probe_rows.push_back('{mk_reclaim(4'd0), 1'b0, '0});
      // Single-descriptor chain, left posted so it blocks a later submit.
      probe_rows.push_back('{mk_submit(64'h0000_1234_5678_9ABC, 32'h0000_1000, 16'h0000, 1'b1),
                             1'b1, mk_rsp(KIND_SUBMITTED, 4'd2, 1'b1, 4'd1, 4'd2)});
      // Open a chain through slots 3..15 and wrap onto 0 and 1.
      for (int i = 0; i < 15; i++)
         probe_rows.push_back('{mk_submit(64'hFEDC_BA98_0000_0000 | 64'(i) << 8,
                                          32'h100 * (i + 1), (i == 7) ? 16'h8000 : 16'h0000,
                                          1'b0), 1'b0, '0});
      // Slot 2 is still in use: busy, chain dropped.
      probe_rows.push_back('{mk_submit(64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 16'h0000, 1'b1),
                             1'b1, mk_rsp(KIND_BUSY, 4'd2, 1'b0, 4'd0, 4'd0)});
      // Walk the dropped chain: sixteen words, the full walk cap.
      probe_rows.push_back('{mk_reclaim(4'd3), 1'b0, '0});
      // Its middle is gone now.
      probe_rows.push_back('{mk_reclaim(4'd4), 1'b1, mk_rsp(KIND_FREED, 4'd4, 1'b0, 4'd0, 4'd0)});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) begin
         row = probe_rows[i];
         n0  = ring_expected.size();
         ring_predict(row.word);
         if (row.typed) begin
            // Replace the prediction with the hand-written response.
            while (ring_expected.size() > n0) void'(ring_expected.pop_back());
            ring_expected.push_back(row.rsp);
         end
         drive_word(row.word);
      end

      // Random part. Start with a chain that fills the whole ring, runs into
      // its own head and is walked as a loop, capped at the ring size.
      posted_heads.delete();
      for (int i = 0; i < RING_SIZE + 1; i++) issue(rand_submit(1'b0));
      issue(rand_reclaim(4'($urandom_range(0, 15))));

      // Then mostly well-formed chains and reclaims of posted heads, with
      // broken chains and stray reclaims as noise.
      while (words_sent < STIM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (live_slots() > 12) pick = 60;
         if (pick < 50) begin
            len = $urandom_range(1, 3);
            for (int i = 1; i <= len; i++) issue(rand_submit(i == len));
         end else if (pick < 80) begin
            if (posted_heads.size() != 0)
               issue(rand_reclaim(posted_heads.pop_front()));
            else
               issue(rand_reclaim($urandom_range(0, 1) ? pred_next_free
                                                        : 4'($urandom_range(0, 15))));
         end else if (pick < 90) begin
            len = $urandom_range(1, 2);
            for (int i = 0; i < len; i++) issue(rand_submit(1'b0));
         end else begin
            issue(rand_reclaim(4'($urandom_range(0, 15))));
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed response, then watch for strays.
      while (ring_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d request words (%0d submits, %0d reclaims), %0d response words",
               words_sent, submits_seen, reclaims_seen, responses_seen);
      $display("tb: %0d chains posted, %0d busy slots hit, %0d mismatches",
               chains_posted, busy_seen, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: virtqueue_descriptor_ring_unit.f
hdl/vdr_pkg.sv
hdl/virtqueue_descriptor_ring_unit.sv
tb/sv/tb.sv
